/* sv/cqd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Coefficient quantizer package
// Shared widths, register indexes, the lane settings type and its derivation.
// ----------------------------------------------------------------------------
package cqd_pkg;

	localparam int LANES            = 4;
	localparam int MAX_BLOCK_COEFFS = 1024;
	localparam int COEFF_W          = 24;
	localparam int LEVEL_W          = 16;
	localparam int RECON_W          = 32;
	localparam int AC_W             = 16;
	localparam int CFG_W            = 32;
	localparam int ACC_W            = $clog2(MAX_BLOCK_COEFFS + 1);
	localparam int CNT_W            = $clog2(LANES + 1);

	typedef enum logic [2:0] {
		REG_LOG_SCALE   = 3'd0,
		REG_ZBIN        = 3'd1,
		REG_ROUND       = 3'd2,
		REG_QUANT       = 3'd3,
		REG_QUANT_SHIFT = 3'd4,
		REG_DEQUANT     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         ls;
		logic signed [15:0] ac_thr;
		logic signed [15:0] ac_add;
		logic signed [15:0] ac_qm;
		logic signed [15:0] ac_sh;
		logic signed [15:0] ac_iq;
		logic [16:0]        dc_thr;
		logic [16:0]        dc_add;
		logic [15:0]        dc_q;
		logic [15:0]        dc_qs;
		logic [15:0]        dc_dq;
	} cfg_t;

	typedef struct packed {
		logic dc;
		logic pass;
		logic neg;
		logic zero;
	} lane_flags_t;

	function automatic logic [16:0] round_scale(input logic [15:0] x, input logic [1:0] ls);
		logic [16:0] half;
		logic [16:0] sum;
		half = (17'd1 << ls) >> 1;
		sum = {1'b0, x} + half;
		return sum >> ls;
	endfunction

	function automatic cfg_t derive_cfg(input logic [1:0] log_scale, input logic [31:0] zbin,
			input logic [31:0] rnd, input logic [31:0] qnt, input logic [31:0] qsh,
			input logic [31:0] deq);
		cfg_t c;
		logic [1:0] ls;
		logic [16:0] tmp;
		logic [17:0] shx;
		ls = (log_scale == 2'd3) ? 2'd2 : log_scale;
		c.ls = ls;
		tmp = round_scale(zbin[31:16], ls);
		c.ac_thr = tmp[15:0];
		tmp = round_scale(rnd[31:16], ls);
		c.ac_add = tmp[15:0];
		c.ac_qm = qnt[31:16];
		shx = {2'b00, qsh[31:16]} << ls;
		c.ac_sh = shx[15:0];
		c.ac_iq = deq[31:16];
		c.dc_thr = round_scale(zbin[15:0], ls);
		c.dc_add = round_scale(rnd[15:0], ls);
		c.dc_q = qnt[15:0];
		c.dc_qs = qsh[15:0];
		c.dc_dq = deq[15:0];
		return c;
	endfunction

endpackage
`default_nettype wire

/* sv/cqd_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Coefficient quantizer lane
// Four-stage dead-zone quantizer and dequantizer for one coefficient, with a
// DC mode in 32-bit arithmetic and an AC mode in 16-bit arithmetic.
// ----------------------------------------------------------------------------
module cqd_lane import cqd_pkg::*; (
	input  logic                       clk,
	input  logic                       adv,
	input  cfg_t                       cfg,
	input  logic signed [COEFF_W-1:0]  coeff,
	input  logic                       is_dc,
	output logic signed [LEVEL_W-1:0]  level,
	output logic signed [RECON_W-1:0]  recon,
	output logic                       nonzero
);

	logic                neg0;
	logic                zero0;
	logic [COEFF_W-1:0]  abs0;
	logic [COEFF_W:0]    dc_sum;
	logic [15:0]         dc_m;
	logic                dc_pass;
	logic signed [15:0]  c16;
	logic signed [15:0]  mag;
	logic signed [16:0]  ac_sum;
	logic [15:0]         ac_m;
	logic                ac_pass;
	lane_flags_t         flags0;

	logic [15:0]         m_s1;
	lane_flags_t         flags_s1;
	logic signed [16:0]  opa1, opb1;
	logic signed [33:0]  p1;

	logic [31:0]         p1_s2;
	logic [15:0]         m_s2;
	lane_flags_t         flags_s2;
	logic [15:0]         t2;
	logic signed [16:0]  opa2, opb2;
	logic signed [33:0]  p2;

	logic [31:0]         p2_s3;
	lane_flags_t         flags_s3;
	logic [31:0]         dc_shifted;
	logic [15:0]         l_raw;
	logic [15:0]         l3;
	logic signed [16:0]  opa3, opb3;
	logic signed [33:0]  p3;

	logic [15:0]         l_s4;
	logic signed [31:0]  p3_s4;
	lane_flags_t         flags_s4;
	logic signed [31:0]  r32;
	logic signed [15:0]  r16;
	logic signed [31:0]  rv;
	logic signed [31:0]  lv;
	logic                neg_apply;
	logic                clear;
	logic signed [31:0]  lv_f;
	logic signed [31:0]  rv_f;

	always_comb begin
		neg0 = coeff[COEFF_W-1];
		zero0 = (coeff == '0);
		abs0 = neg0 ? COEFF_W'(-coeff) : coeff;
		dc_pass = abs0 >= COEFF_W'(cfg.dc_thr);
		dc_sum = {1'b0, abs0} + (COEFF_W + 1)'(cfg.dc_add);
		dc_m = (dc_sum > (COEFF_W + 1)'(16'h7FFF)) ? 16'h7FFF : dc_sum[15:0];
		if (coeff[COEFF_W-1:15] == '0 || coeff[COEFF_W-1:15] == '1) begin
			c16 = coeff[15:0];
		end else begin
			c16 = neg0 ? 16'sh8000 : 16'sh7FFF;
		end
		mag = neg0 ? -c16 : c16;
		ac_pass = mag >= cfg.ac_thr;
		ac_sum = {mag[15], mag} + {cfg.ac_add[15], cfg.ac_add};
		if (ac_sum[16] != ac_sum[15]) begin
			ac_m = ac_sum[16] ? 16'h8000 : 16'h7FFF;
		end else begin
			ac_m = ac_sum[15:0];
		end
		flags0.dc = is_dc;
		flags0.pass = is_dc ? dc_pass : ac_pass;
		flags0.neg = neg0;
		flags0.zero = zero0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1 <= is_dc ? dc_m : ac_m;
			flags_s1 <= flags0;
		end
	end

	always_comb begin
		opa1 = flags_s1.dc ? {1'b0, m_s1} : {m_s1[15], m_s1};
		opb1 = flags_s1.dc ? {1'b0, cfg.dc_q} : {cfg.ac_qm[15], cfg.ac_qm};
		p1 = opa1 * opb1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s2 <= p1[31:0];
			m_s2 <= m_s1;
			flags_s2 <= flags_s1;
		end
	end

	always_comb begin
		t2 = p1_s2[31:16] + m_s2;
		opa2 = flags_s2.dc ? {1'b0, t2} : {t2[15], t2};
		opb2 = flags_s2.dc ? {1'b0, cfg.dc_qs} : {cfg.ac_sh[15], cfg.ac_sh};
		p2 = opa2 * opb2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p2_s3 <= p2[31:0];
			flags_s3 <= flags_s2;
		end
	end

	always_comb begin
		dc_shifted = p2_s3 << cfg.ls;
		l_raw = flags_s3.dc ? dc_shifted[31:16] : p2_s3[31:16];
		l3 = flags_s3.pass ? l_raw : 16'h0000;
		opa3 = {l3[15], l3};
		opb3 = flags_s3.dc ? {1'b0, cfg.dc_dq} : {cfg.ac_iq[15], cfg.ac_iq};
		p3 = opa3 * opb3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s4 <= l3;
			p3_s4 <= p3[31:0];
			flags_s4 <= flags_s3;
		end
	end

	always_comb begin
		r32 = p3_s4 >>> cfg.ls;
		r16 = $signed(p3_s4[15:0]) >>> cfg.ls;
		rv = flags_s4.dc ? r32 : {{16{r16[15]}}, r16};
		lv = {{16{l_s4[15]}}, l_s4};
		neg_apply = flags_s4.dc ? (flags_s4.neg || flags_s4.zero) : flags_s4.neg;
		clear = !flags_s4.dc && flags_s4.zero;
		if (clear) begin
			lv_f = '0;
			rv_f = '0;
		end else if (neg_apply) begin
			lv_f = -lv;
			rv_f = -rv;
		end else begin
			lv_f = lv;
			rv_f = rv;
		end
		level = lv_f[15:0];
		recon = flags_s4.dc ? rv_f : {{16{rv_f[15]}}, rv_f[15:0]};
		nonzero = |lv_f[15:0];
	end

endmodule
`default_nettype wire

/* sv/cqd_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Coefficient quantizer merge stage
// Counts the nonzero levels of all lanes, keeps the saturating block count and
// holds the result word in the output register.
// ----------------------------------------------------------------------------
module cqd_merge import cqd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       valid_s4,
	input  logic                       first_s4,
	input  logic                       last_s4,
	input  logic signed [LEVEL_W-1:0]  lane_level [LANES],
	input  logic signed [RECON_W-1:0]  lane_recon [LANES],
	input  logic [LANES-1:0]           lane_nonzero,
	output logic                       valid_s5,
	output logic signed [LEVEL_W-1:0]  level_s5 [LANES],
	output logic signed [RECON_W-1:0]  recon_s5 [LANES],
	output logic [ACC_W-1:0]           total_s5,
	output logic                       done_s5
);

	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt;
	logic [ACC_W-1:0] base;
	logic [ACC_W:0]   sum;
	logic [ACC_W-1:0] sat;

	always_comb begin
		cnt = '0;
		for (int i = 0; i < LANES; i++) begin
			cnt = cnt + CNT_W'(lane_nonzero[i]);
		end
		base = first_s4 ? '0 : acc_q;
		sum = {1'b0, base} + (ACC_W + 1)'(cnt);
		sat = (sum > (ACC_W + 1)'(MAX_BLOCK_COEFFS)) ? ACC_W'(MAX_BLOCK_COEFFS) : sum[ACC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			acc_q <= '0;
		end else if (adv) begin
			valid_s5 <= valid_s4;
			if (valid_s4) begin
				acc_q <= last_s4 ? '0 : sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			level_s5 <= lane_level;
			recon_s5 <= lane_recon;
			total_s5 <= last_s4 ? sat : '0;
			done_s5 <= last_s4;
		end
	end

endmodule
`default_nettype wire

/* sv/coeff_quant_dequant_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Coefficient quantizer and dequantizer
// Dead-zone quantization of four coefficients per word with a running count
// of nonzero levels per block.
// ----------------------------------------------------------------------------
// The unit accepts one word of four coefficients every clock cycle while
// coeff_stall is low. Each result passes four lane stages, set by the three
// dependent multiplications of each lane, and then the output register. All
// stages advance together; while a result waits under stall, the whole
// pipeline holds and coeff_stall is raised. Lane 0 of a word flagged
// first_of_block runs in DC mode. The user must write configuration through
// the plain write port only while it is idle; the unit does not enforce it.
module coeff_quant_dequant_unit import cqd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [2:0]                 cfg_index,
	input  logic [CFG_W-1:0]           cfg_wdata,
	input  logic                       coeff_valid,
	output logic                       coeff_stall,
	input  logic signed [COEFF_W-1:0]  coeff_lane0,
	input  logic signed [COEFF_W-1:0]  coeff_lane1,
	input  logic signed [COEFF_W-1:0]  coeff_lane2,
	input  logic signed [COEFF_W-1:0]  coeff_lane3,
	input  logic                       first_of_block,
	input  logic                       last_of_block,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [LEVEL_W-1:0]  level_lane0,
	output logic signed [LEVEL_W-1:0]  level_lane1,
	output logic signed [LEVEL_W-1:0]  level_lane2,
	output logic signed [LEVEL_W-1:0]  level_lane3,
	output logic signed [RECON_W-1:0]  recon_lane0,
	output logic signed [AC_W-1:0]     recon_lane1,
	output logic signed [AC_W-1:0]     recon_lane2,
	output logic signed [AC_W-1:0]     recon_lane3,
	output logic [ACC_W-1:0]           nonzero_total,
	output logic                       block_done
);

	logic [1:0]        log_scale_q;
	logic [CFG_W-1:0]  zbin_q;
	logic [CFG_W-1:0]  round_q;
	logic [CFG_W-1:0]  quant_q;
	logic [CFG_W-1:0]  quant_shift_q;
	logic [CFG_W-1:0]  dequant_q;
	cfg_t              cfg;

	logic adv;
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic first_s1, first_s2, first_s3, first_s4;
	logic last_s1, last_s2, last_s3, last_s4;

	logic signed [COEFF_W-1:0] coeff [LANES];
	logic signed [LEVEL_W-1:0] lane_level [LANES];
	logic signed [RECON_W-1:0] lane_recon [LANES];
	logic [LANES-1:0]          lane_nonzero;
	logic signed [LEVEL_W-1:0] level_s5 [LANES];
	logic signed [RECON_W-1:0] recon_s5 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_scale_q <= '0;
			zbin_q <= '0;
			round_q <= '0;
			quant_q <= '0;
			quant_shift_q <= '0;
			dequant_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LOG_SCALE:   log_scale_q <= cfg_wdata[1:0];
				REG_ZBIN:        zbin_q <= cfg_wdata;
				REG_ROUND:       round_q <= cfg_wdata;
				REG_QUANT:       quant_q <= cfg_wdata;
				REG_QUANT_SHIFT: quant_shift_q <= cfg_wdata;
				REG_DEQUANT:     dequant_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = derive_cfg(log_scale_q, zbin_q, round_q, quant_q, quant_shift_q, dequant_q);

	assign adv = !(result_valid && result_stall);
	assign coeff_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= coeff_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s1 <= first_of_block;
			first_s2 <= first_s1;
			first_s3 <= first_s2;
			first_s4 <= first_s3;
			last_s1 <= last_of_block;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			last_s4 <= last_s3;
		end
	end

	assign coeff[0] = coeff_lane0;
	assign coeff[1] = coeff_lane1;
	assign coeff[2] = coeff_lane2;
	assign coeff[3] = coeff_lane3;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		cqd_lane u_lane (
			.clk     (clk),
			.adv     (adv),
			.cfg     (cfg),
			.coeff   (coeff[g]),
			.is_dc   ((g == 0) && first_of_block),
			.level   (lane_level[g]),
			.recon   (lane_recon[g]),
			.nonzero (lane_nonzero[g])
		);
	end

	cqd_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.valid_s4     (valid_s4),
		.first_s4     (first_s4),
		.last_s4      (last_s4),
		.lane_level   (lane_level),
		.lane_recon   (lane_recon),
		.lane_nonzero (lane_nonzero),
		.valid_s5     (result_valid),
		.level_s5     (level_s5),
		.recon_s5     (recon_s5),
		.total_s5     (nonzero_total),
		.done_s5      (block_done)
	);

	assign level_lane0 = level_s5[0];
	assign level_lane1 = level_s5[1];
	assign level_lane2 = level_s5[2];
	assign level_lane3 = level_s5[3];
	assign recon_lane0 = recon_s5[0];
	assign recon_lane1 = recon_s5[1][AC_W-1:0];
	assign recon_lane2 = recon_s5[2][AC_W-1:0];
	assign recon_lane3 = recon_s5[3][AC_W-1:0];

endmodule
`default_nettype wire
